>>> hw/rtl/seven_segment_digit_reader_defines.svh
// Assertion macros for the seven segment digit reader.
// Expects signals named clock and reset in the including module.
`ifndef SEVEN_SEGMENT_DIGIT_READER_DEFINES_SVH
`define SEVEN_SEGMENT_DIGIT_READER_DEFINES_SVH

// same-cycle implication
`define SSDR_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define SSDR_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hw/rtl/ssdr_pkg.sv
// Shared types, constants and constant dividers for the digit reader.
// No dependencies.
`default_nettype none

package ssdr_pkg;

   localparam int IMAGE_SIZE = 1024;

   localparam int CoordW = 12;
   localparam int BalW   = 11;
   localparam int NumSeg = 7;

   typedef logic [CoordW-1:0] coord_type;

   typedef enum logic [2:0] {
      REG_RECT_LEFT       = 3'd0,
      REG_RECT_TOP        = 3'd1,
      REG_RECT_WIDTH      = 3'd2,
      REG_RECT_HEIGHT     = 3'd3,
      REG_WHITE_THRESHOLD = 3'd4
   } reg_index_type;

   localparam logic [9:0]  RESET_LEFT      = 10'd0;
   localparam logic [9:0]  RESET_TOP       = 10'd0;
   localparam logic [10:0] RESET_WIDTH     = 11'd1;
   localparam logic [10:0] RESET_HEIGHT    = 11'd1;
   localparam logic [7:0]  RESET_THRESHOLD = 8'd100;

   localparam logic [6:0] DIGIT_CODES [10] = '{
      7'd63, 7'd0, 7'd91, 7'd79, 7'd102, 7'd109, 7'd125, 7'd7, 7'd127, 7'd111
   };

   // box geometry shared by the match stages and the tally
   typedef struct packed {
      coord_type  left;
      coord_type  top;
      coord_type  mid_col;
      coord_type  right_lo;
      coord_type  right_hi;
      coord_type  left_hi;
      coord_type  row_up;
      coord_type  row_dn;
      coord_type  seg0_hi;
      coord_type  seg3_lo;
      coord_type  seg3_hi;
      coord_type  seg6_lo;
      coord_type  seg6_hi;
      logic       tall;
      logic [7:0] threshold;
   } geom_type;

   typedef struct packed {
      logic [NumSeg-1:0] hits;
      logic              bright;
      logic              frame_end;
   } hit_type;

   // exact n/3 for n below 2**16
   function automatic logic [15:0] div3(input logic [15:0] n);
      logic [31:0] p;
      p = 32'(n) * 32'd43691;
      return 16'(p[31:17]);
   endfunction

   // exact n/5 for n below 2**16
   function automatic logic [15:0] div5(input logic [15:0] n);
      logic [31:0] p;
      p = 32'(n) * 32'd52429;
      return 16'(p[31:18]);
   endfunction

   // {valid, digit}
   function automatic logic [4:0] digit_of(input logic [6:0] code);
      logic [4:0] r;
      r = '0;
      for (int k = 0; k < 10; k++) begin
         if (code == DIGIT_CODES[k]) begin
            r = {1'b1, 4'(k)};
         end
      end
      return r;
   endfunction

endpackage

`default_nettype wire

>>> hw/rtl/seven_segment_digit_reader.sv
// Seven segment digit reader: judges one digit in a configured box of a pixel stream.
// Instantiates ssdr_geom, ssdr_match and ssdr_tally; depends on ssdr_pkg.
//
// The reader takes one pixel per clock unless stalled, and a frame-end pixel yields
// one result. The pixel path is three registers deep (input, row tests, column
// tests) followed by the balance update and the result register; the only stall is
// a frame-end pixel meeting a result that has not yet been taken, so a held result
// costs nothing until the next frame end. Register writes reach the derived box
// geometry through its registered stages, which a pixel accepted right after the
// write already sees; write only while no pixels are in flight. Widths and heights
// of zero act as one.
`default_nettype none

module seven_segment_digit_reader
   import ssdr_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,  // pixel_row[9:0], pixel_column[19:10], pixel_value[27:20]
   input  wire logic        req_tlast,  // frame_end
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata,  // segment_code[6:0], digit[10:7]
   output logic             rsp_tuser,  // digit_valid
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [2:0]  csr_index,
   input  wire logic [10:0] csr_wdata
);

   geom_type   geom;
   hit_type    hit;
   logic       hit_valid, hit_ready;
   logic [6:0] code;
   logic [3:0] digit;

   assign csr_ready = !reset;

   ssdr_geom u_geom (
      .clock     (clock),
      .reset     (reset),
      .csr_wr    (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .geom      (geom)
   );

   ssdr_match u_match (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (req_tvalid),
      .in_ready     (req_tready),
      .in_row       (req_tdata[9:0]),
      .in_col       (req_tdata[19:10]),
      .in_value     (req_tdata[27:20]),
      .in_frame_end (req_tlast),
      .geom         (geom),
      .hit_valid    (hit_valid),
      .hit_ready    (hit_ready),
      .hit          (hit)
   );

   ssdr_tally u_tally (
      .clock           (clock),
      .reset           (reset),
      .hit_valid       (hit_valid),
      .hit_ready       (hit_ready),
      .hit             (hit),
      .tall            (geom.tall),
      .out_valid       (rsp_tvalid),
      .out_ready       (rsp_tready),
      .out_code        (code),
      .out_digit       (digit),
      .out_digit_valid (rsp_tuser)
   );

   assign rsp_tdata = {5'd0, digit, code};

endmodule

`default_nettype wire

>>> hw/rtl/ssdr_geom.sv
// Configuration registers and the two-stage box geometry derived from them.
// Depends on ssdr_pkg.
`default_nettype none

module ssdr_geom
   import ssdr_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_wr,
   input  wire logic [2:0]  csr_index,
   input  wire logic [10:0] csr_wdata,
   output geom_type         geom
);

   logic [9:0]  left_ff, top_ff;
   logic [10:0] width_ff, height_ff;
   logic [7:0]  thresh_ff;

   logic [10:0] w0, h0, eff_w_in, eff_w_ff, h_ff;
   logic        eff;
   coord_type   row_up_ff, row_dn_ff, seg0_hi_ff, seg3_lo_ff, seg3_hi_ff;
   coord_type   seg6_lo_ff, seg6_hi_ff;
   coord_type   mid_col_ff, right_lo_ff, right_hi_ff, left_hi_ff;
   logic        tall_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff   <= RESET_LEFT;
         top_ff    <= RESET_TOP;
         width_ff  <= RESET_WIDTH;
         height_ff <= RESET_HEIGHT;
         thresh_ff <= RESET_THRESHOLD;
      end else if (csr_wr) begin
         unique case (csr_index)
            REG_RECT_LEFT:       left_ff   <= csr_wdata[9:0];
            REG_RECT_TOP:        top_ff    <= csr_wdata[9:0];
            REG_RECT_WIDTH:      width_ff  <= csr_wdata;
            REG_RECT_HEIGHT:     height_ff <= csr_wdata;
            REG_WHITE_THRESHOLD: thresh_ff <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      w0  = (width_ff == '0) ? 11'd1 : width_ff;
      h0  = (height_ff == '0) ? 11'd1 : height_ff;
      eff = (w0 < h0) && ((14'(w0) * 14'd5) >= (14'(h0) * 14'd4));
      eff_w_in = eff ? 11'(div3(16'({w0, 1'b0}))) : w0;
   end

   // stage 1: effective width and row bounds
   always_ff @(posedge clock) begin
      eff_w_ff   <= eff_w_in;
      h_ff       <= h0;
      row_up_ff  <= coord_type'(top_ff) + coord_type'(h0[10:2]);
      row_dn_ff  <= coord_type'(top_ff) + coord_type'((13'(h0) * 13'd3) >> 2);
      seg0_hi_ff <= coord_type'(top_ff) + coord_type'(div5(16'(h0)));
      seg3_lo_ff <= coord_type'(top_ff) + coord_type'(div5(16'(h0) * 16'd4));
      seg3_hi_ff <= coord_type'(top_ff) + coord_type'(h0);
      seg6_lo_ff <= coord_type'(top_ff) + coord_type'(div5(16'(h0) * 16'd2));
      seg6_hi_ff <= coord_type'(top_ff) + coord_type'(div5(16'(h0) * 16'd3));
   end

   // stage 2: column bounds and the narrow-box flag
   always_ff @(posedge clock) begin
      mid_col_ff  <= coord_type'(left_ff) + coord_type'(eff_w_ff[10:1]);
      right_lo_ff <= coord_type'(left_ff) + coord_type'(div5(16'(eff_w_ff) * 16'd4));
      right_hi_ff <= coord_type'(left_ff) + coord_type'(eff_w_ff);
      left_hi_ff  <= coord_type'(left_ff) + coord_type'(div5(16'(eff_w_ff)));
      tall_ff     <= 13'(h_ff) >= (13'(eff_w_ff) * 13'd4);
   end

   always_comb begin
      geom.left      = coord_type'(left_ff);
      geom.top       = coord_type'(top_ff);
      geom.mid_col   = mid_col_ff;
      geom.right_lo  = right_lo_ff;
      geom.right_hi  = right_hi_ff;
      geom.left_hi   = left_hi_ff;
      geom.row_up    = row_up_ff;
      geom.row_dn    = row_dn_ff;
      geom.seg0_hi   = seg0_hi_ff;
      geom.seg3_lo   = seg3_lo_ff;
      geom.seg3_hi   = seg3_hi_ff;
      geom.seg6_lo   = seg6_lo_ff;
      geom.seg6_hi   = seg6_hi_ff;
      geom.tall      = tall_ff;
      geom.threshold = thresh_ff;
   end

endmodule

`default_nettype wire

>>> hw/rtl/ssdr_match.sv
// Pixel pipeline: input register, row tests, column tests into segment hits.
// Depends on ssdr_pkg.
`default_nettype none

module ssdr_match
   import ssdr_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        in_valid,
   output logic             in_ready,
   input  wire logic [9:0]  in_row,
   input  wire logic [9:0]  in_col,
   input  wire logic [7:0]  in_value,
   input  wire logic        in_frame_end,
   input  geom_type         geom,
   output logic             hit_valid,
   input  wire logic        hit_ready,
   output hit_type          hit
);

   logic       a_valid_ff, b_valid_ff, c_valid_ff;
   logic       a_ready, b_ready, c_ready;
   logic [9:0] a_row_ff, a_col_ff, b_col_ff;
   logic [7:0] a_value_ff;
   logic       a_fend_ff;

   logic b_ok_ff, b_up_ff, b_dn_ff, b_in0_ff, b_in3_ff, b_in6_ff, b_bright_ff, b_fend_ff;
   logic ok_in, up_in, dn_in, in0_in, in3_in, in6_in, bright_in;
   logic mid, rlo, llo;
   hit_type hit_in, hit_ff;
   coord_type row_x, col_x;

   assign c_ready  = !c_valid_ff || hit_ready;
   assign b_ready  = !b_valid_ff || c_ready;
   assign a_ready  = !a_valid_ff || b_ready;
   assign in_ready = a_ready && !reset;

   // stage A: hold the accepted item
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (a_ready) begin
         a_valid_ff <= in_valid;
      end
      if (a_ready && in_valid) begin
         a_row_ff   <= in_row;
         a_col_ff   <= in_col;
         a_value_ff <= in_value;
         a_fend_ff  <= in_frame_end;
      end
   end

   always_comb begin
      row_x     = coord_type'(a_row_ff);
      ok_in     = (32'(a_row_ff) < IMAGE_SIZE) && (32'(a_col_ff) < IMAGE_SIZE);
      up_in     = row_x == geom.row_up;
      dn_in     = row_x == geom.row_dn;
      in0_in    = (row_x >= geom.top) && (row_x < geom.seg0_hi);
      in3_in    = (row_x >= geom.seg3_lo) && (row_x < geom.seg3_hi);
      in6_in    = (row_x >= geom.seg6_lo) && (row_x < geom.seg6_hi);
      bright_in = a_value_ff > geom.threshold;
   end

   // stage B: row tests
   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (b_ready) begin
         b_valid_ff <= a_valid_ff;
      end
      if (b_ready && a_valid_ff) begin
         b_col_ff    <= a_col_ff;
         b_ok_ff     <= ok_in;
         b_up_ff     <= up_in;
         b_dn_ff     <= dn_in;
         b_in0_ff    <= in0_in;
         b_in3_ff    <= in3_in;
         b_in6_ff    <= in6_in;
         b_bright_ff <= bright_in;
         b_fend_ff   <= a_fend_ff;
      end
   end

   always_comb begin
      col_x = coord_type'(b_col_ff);
      mid   = col_x == geom.mid_col;
      rlo   = (col_x >= geom.right_lo) && (col_x < geom.right_hi);
      llo   = (col_x >= geom.left) && (col_x < geom.left_hi);
      hit_in.hits[0]   = b_ok_ff && mid && b_in0_ff;
      hit_in.hits[1]   = b_ok_ff && b_up_ff && rlo;
      hit_in.hits[2]   = b_ok_ff && b_dn_ff && rlo;
      hit_in.hits[3]   = b_ok_ff && mid && b_in3_ff;
      hit_in.hits[4]   = b_ok_ff && b_dn_ff && llo;
      hit_in.hits[5]   = b_ok_ff && b_up_ff && llo;
      hit_in.hits[6]   = b_ok_ff && mid && b_in6_ff;
      hit_in.bright    = b_bright_ff;
      hit_in.frame_end = b_fend_ff;
   end

   // stage C: segment hits
   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
      end else if (c_ready) begin
         c_valid_ff <= b_valid_ff;
      end
      if (c_ready && b_valid_ff) begin
         hit_ff <= hit_in;
      end
   end

   assign hit_valid = c_valid_ff;
   assign hit       = hit_ff;

endmodule

`default_nettype wire

>>> hw/rtl/ssdr_tally.sv
// Segment balances, frame-end decision, digit lookup and result register.
// Depends on ssdr_pkg and the assertion macro header.
`default_nettype none
`include "seven_segment_digit_reader_defines.svh"

module ssdr_tally
   import ssdr_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        hit_valid,
   output logic             hit_ready,
   input  hit_type          hit,
   input  wire logic        tall,
   output logic             out_valid,
   input  wire logic        out_ready,
   output logic [6:0]       out_code,
   output logic [3:0]       out_digit,
   output logic             out_digit_valid
);

   logic [NumSeg-1:0][BalW-1:0] bal_ff, bal_in, bal_nx;
   logic             rsp_valid_ff;
   logic [6:0]       code_ff;
   logic [3:0]       digit_ff;
   logic             valid_ff;
   logic             slot_free, take, out_wr;
   logic [6:0]       code_c;
   logic [4:0]       look;

   assign slot_free = !rsp_valid_ff || out_ready;
   assign hit_ready = !hit.frame_end || slot_free;
   assign take      = hit_valid && hit_ready;
   assign out_wr    = take && hit.frame_end;

   always_comb begin
      for (int k = 0; k < NumSeg; k++) begin
         bal_nx[k] = bal_ff[k];
         if (hit.hits[k]) begin
            if (hit.bright) begin
               if ($signed(bal_ff[k]) != $signed(11'h3FF)) bal_nx[k] = bal_ff[k] + 11'd1;
            end else begin
               if ($signed(bal_ff[k]) != $signed(11'h400)) bal_nx[k] = bal_ff[k] - 11'd1;
            end
         end
         code_c[k] = $signed(bal_nx[k]) > $signed(11'd0);
      end
      if (tall) code_c = '0;
      look   = digit_of(code_c);
      bal_in = hit.frame_end ? '0 : bal_nx;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bal_ff <= '0;
      end else if (take) begin
         bal_ff <= bal_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_wr) begin
         rsp_valid_ff <= 1'b1;
      end else if (out_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (out_wr) begin
         code_ff  <= code_c;
         digit_ff <= look[3:0];
         valid_ff <= look[4];
      end
   end

   assign out_valid       = rsp_valid_ff;
   assign out_code        = code_ff;
   assign out_digit       = digit_ff;
   assign out_digit_valid = valid_ff;

   `SSDR_ASSERT_NXT(a_bal_clear, out_wr, bal_ff == '0, "balances not cleared after result")
   `SSDR_ASSERT_IMP(a_no_overwrite, out_wr, !rsp_valid_ff || out_ready, "result overwritten")
   `SSDR_ASSERT_NXT(a_tall_zero, out_wr && tall, code_ff == '0, "narrow box code not zero")
   `SSDR_ASSERT_IMP(a_digit_zero, rsp_valid_ff && !valid_ff, digit_ff == '0, "bad digit")

endmodule

`default_nettype wire
